// ----- rtl/core/websocket_frame_deframer_top_macros.svh -----
// Assertion macros for the WebSocket deframer.
// Used by the top level; relies on clk_i and rst_ni being in scope.
`ifndef WEBSOCKET_FRAME_DEFRAMER_TOP_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define WSDF_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("deframer check failed");

// Next-cycle implication, disabled during reset.
`define WSDF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("deframer check failed");

`endif

// ----- rtl/core/wsdf_pkg.sv -----
// Shared types and constants for the WebSocket frame deframer.
// No dependencies.
package wsdf_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 64;
  localparam int unsigned CountW  = 3;
  localparam int unsigned KeyIdxW = 2;
  localparam int unsigned KeyDepth = 4;

  localparam logic EvHeader  = 1'b0;
  localparam logic EvPayload = 1'b1;

  localparam logic [6:0] Len7Ext16 = 7'd126;
  localparam logic [6:0] Len7Ext64 = 7'd127;

  typedef enum logic [5:0] {
    PhFirst   = 6'b000001,
    PhSecond  = 6'b000010,
    PhLen16   = 6'b000100,
    PhLen64   = 6'b001000,
    PhKey     = 6'b010000,
    PhPayload = 6'b100000
  } wsdf_phase_e;

  typedef struct packed {
    logic              event_kind;
    logic              fin_bit;
    logic [2:0]        reserved_bits;
    logic [3:0]        frame_opcode;
    logic              masked;
    logic [LenW-1:0]   payload_length;
    logic [ByteW-1:0]  payload_byte;
    logic [LenW-1:0]   payload_offset;
    logic              frame_end;
  } wsdf_result_t;

endpackage

// ----- rtl/core/wsdf_in_stage.sv -----
// Input register stage of the WebSocket deframer.
// Depends on wsdf_pkg.
module wsdf_in_stage import wsdf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ByteW-1:0] in_byte_i,
  input  logic             advance_i,
  output logic             valid_o,
  output logic [ByteW-1:0] byte_o
);

  logic             valid_q, valid_d;
  logic [ByteW-1:0] byte_q;
  logic             load;

  // The held word leaves in the same cycle a new one may enter.
  assign in_ready_o = !valid_q || advance_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= in_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

// ----- rtl/core/wsdf_parser.sv -----
// Frame header parser and payload unmasker of the WebSocket deframer.
// Depends on wsdf_pkg.
module wsdf_parser import wsdf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [ByteW-1:0] byte_i,
  output logic             res_valid_o,
  output wsdf_result_t     res_o
);

  wsdf_phase_e        phase_q, phase_d;
  logic [CountW-1:0]  count_q, count_d;
  logic               fin_q, fin_d;
  logic [2:0]         rsv_q, rsv_d;
  logic [3:0]         opcode_q, opcode_d;
  logic               mask_q, mask_d;
  logic [LenW-1:0]    len_q, len_d;
  logic [KeyIdxW-1:0] key_idx_q, key_idx_d;
  logic [LenW-1:0]    offset_q, offset_d;
  logic [ByteW-1:0]   key_mem [KeyDepth];
  logic               key_we;
  logic [ByteW-1:0]   data;
  logic               finish;
  logic               len_done;

  always_comb begin
    phase_d     = phase_q;
    count_d     = count_q;
    fin_d       = fin_q;
    rsv_d       = rsv_q;
    opcode_d    = opcode_q;
    mask_d      = mask_q;
    len_d       = len_q;
    key_idx_d   = key_idx_q;
    offset_d    = offset_q;
    key_we      = 1'b0;
    finish      = 1'b0;
    len_done    = 1'b0;
    data        = byte_i;
    res_valid_o = 1'b0;
    res_o       = '0;

    case (phase_q)
      PhSecond: begin
        mask_d  = byte_i[7];
        count_d = '0;
        if (byte_i[6:0] == Len7Ext16) begin
          len_d   = '0;
          phase_d = PhLen16;
        end else if (byte_i[6:0] == Len7Ext64) begin
          len_d   = '0;
          phase_d = PhLen64;
        end else begin
          len_d    = {{(LenW-7){1'b0}}, byte_i[6:0]};
          len_done = 1'b1;
        end
      end
      PhLen16: begin
        len_d = {{(LenW-16){1'b0}}, len_q[7:0], byte_i};
        if (count_q >= CountW'(1)) begin
          len_done = 1'b1;
        end else begin
          count_d = count_q + CountW'(1);
        end
      end
      PhLen64: begin
        len_d = {len_q[LenW-9:0], byte_i};
        if (count_q >= CountW'(7)) begin
          len_done = 1'b1;
        end else begin
          count_d = count_q + CountW'(1);
        end
      end
      PhKey: begin
        key_we = 1'b1;
        if (count_q >= CountW'(3)) begin
          finish = 1'b1;
        end else begin
          count_d = count_q + CountW'(1);
        end
      end
      PhPayload: begin
        if (mask_q) begin
          data      = byte_i ^ key_mem[key_idx_q];
          key_idx_d = key_idx_q + KeyIdxW'(1);
        end
        offset_d    = offset_q + LenW'(1);
        res_valid_o = 1'b1;
        res_o.event_kind     = EvPayload;
        res_o.payload_byte   = data;
        res_o.payload_offset = offset_d;
        res_o.frame_end      = (offset_d == len_q);
        if (offset_d == len_q) begin
          phase_d = PhFirst;
        end
      end
      default: begin
        fin_d    = byte_i[7];
        rsv_d    = byte_i[6:4];
        opcode_d = byte_i[3:0];
        count_d  = '0;
        phase_d  = PhSecond;
      end
    endcase

    // Once the length is known, a key may still follow.
    if (len_done) begin
      count_d = '0;
      if (mask_d) begin
        phase_d = PhKey;
      end else begin
        finish = 1'b1;
      end
    end

    if (finish) begin
      key_idx_d   = '0;
      offset_d    = '0;
      count_d     = '0;
      res_valid_o = 1'b1;
      res_o.event_kind = EvHeader;
      res_o.frame_end  = (len_d == '0);
      phase_d = (len_d == '0) ? PhFirst : PhPayload;
    end

    res_o.fin_bit        = fin_d;
    res_o.reserved_bits  = rsv_d;
    res_o.frame_opcode   = opcode_d;
    res_o.masked         = mask_d;
    res_o.payload_length = len_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhFirst;
      count_q   <= '0;
      fin_q     <= 1'b0;
      rsv_q     <= '0;
      opcode_q  <= '0;
      mask_q    <= 1'b0;
      len_q     <= '0;
      key_idx_q <= '0;
      offset_q  <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      count_q   <= count_d;
      fin_q     <= fin_d;
      rsv_q     <= rsv_d;
      opcode_q  <= opcode_d;
      mask_q    <= mask_d;
      len_q     <= len_d;
      key_idx_q <= key_idx_d;
      offset_q  <= offset_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && key_we) begin
      key_mem[count_q[KeyIdxW-1:0]] <= byte_i;
    end
  end

endmodule

// ----- rtl/core/wsdf_out_stage.sv -----
// Result register stage of the WebSocket deframer.
// Depends on wsdf_pkg.
module wsdf_out_stage import wsdf_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         load_i,
  input  wsdf_result_t res_i,
  input  logic         out_ready_i,
  output logic         out_valid_o,
  output wsdf_result_t res_o
);

  logic         valid_q, valid_d;
  wsdf_result_t res_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// ----- rtl/core/websocket_frame_deframer_top.sv -----
// WebSocket (RFC 6455) frame deframer, one stream byte per word on the input side.
// It parses each frame header, emits a header word once the header is complete,
// then emits every payload byte unmasked with its running offset and an end mark
// on the last one. The block accepts one byte per clock while result words are
// taken. A byte passes through one input register and one result register, and the
// parse state is updated as it moves between the two. Its result word is valid once the
// byte has moved into the result register and can be taken at the next rising edge.
// A byte waits in the input register while the result register holds a word that
// is not being taken, and the input then stalls. Header bytes other than the last
// give no result. Fields are not validated.
`include "websocket_frame_deframer_top_macros.svh"

module websocket_frame_deframer_top import wsdf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ByteW-1:0] in_byte_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             event_kind_o,
  output logic             fin_bit_o,
  output logic [2:0]       reserved_bits_o,
  output logic [3:0]       frame_opcode_o,
  output logic             masked_o,
  output logic [LenW-1:0]  payload_length_o,
  output logic [ByteW-1:0] payload_byte_o,
  output logic [LenW-1:0]  payload_offset_o,
  output logic             frame_end_o
);

  logic             held_valid;
  logic [ByteW-1:0] held_byte;
  logic             advance;
  logic             res_valid;
  wsdf_result_t     res_next;
  wsdf_result_t     res_out;
  logic             hdr_word;
  logic             pay_word;
  logic             out_stall;

  // A held byte moves on when the result register is free or draining.
  assign advance = held_valid && (!out_valid_o || out_ready_i);

  wsdf_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .advance_i  (advance),
    .valid_o    (held_valid),
    .byte_o     (held_byte)
  );

  wsdf_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .byte_i      (held_byte),
    .res_valid_o (res_valid),
    .res_o       (res_next)
  );

  wsdf_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && res_valid),
    .res_i       (res_next),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .res_o       (res_out)
  );

  assign event_kind_o     = res_out.event_kind;
  assign fin_bit_o        = res_out.fin_bit;
  assign reserved_bits_o  = res_out.reserved_bits;
  assign frame_opcode_o   = res_out.frame_opcode;
  assign masked_o         = res_out.masked;
  assign payload_length_o = res_out.payload_length;
  assign payload_byte_o   = res_out.payload_byte;
  assign payload_offset_o = res_out.payload_offset;
  assign frame_end_o      = res_out.frame_end;

  assign hdr_word  = out_valid_o && (event_kind_o == EvHeader);
  assign pay_word  = out_valid_o && (event_kind_o == EvPayload);
  assign out_stall = out_valid_o && !out_ready_i;

  `WSDF_ASSERT_IMPL(a_hdr_end_zero_len, hdr_word && frame_end_o, payload_length_o == '0)
  `WSDF_ASSERT_IMPL(a_hdr_no_data, hdr_word, payload_byte_o == '0 && payload_offset_o == '0)
  `WSDF_ASSERT_IMPL(a_pay_end_match, pay_word, frame_end_o == (payload_offset_o == payload_length_o))
  `WSDF_ASSERT_NEXT(a_result_held, out_stall, out_valid_o && $stable(res_out))

endmodule

// ----- dv/wsdf_stream_checker.sv -----
// Checker for the WebSocket frame deframer: decodes the accepted stream bytes
// itself and compares every result word with the oldest decoded event.
// Depends on wsdf_pkg for the phase encoding, the result layout and the codes.
`timescale 1ns / 100ps

module wsdf_stream_checker import wsdf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  logic [ByteW-1:0] in_byte_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  logic             event_kind_i,
  input  logic             fin_bit_i,
  input  logic [2:0]       reserved_bits_i,
  input  logic [3:0]       frame_opcode_i,
  input  logic             masked_i,
  input  logic [LenW-1:0]  payload_length_i,
  input  logic [ByteW-1:0] payload_byte_i,
  input  logic [LenW-1:0]  payload_offset_i,
  input  logic             frame_end_i,
  output int               fail_count_o,
  output int               pending_o,
  output int               header_words_o,
  output int               payload_words_o
);

  wsdf_phase_e      phase_q = PhFirst;
  logic [2:0]       count_q = '0;
  logic             fin_q = 1'b0;
  logic [2:0]       rsv_q = '0;
  logic [3:0]       opcode_q = '0;
  logic             masked_q = 1'b0;
  logic [LenW-1:0]  len_q = '0;
  logic [ByteW-1:0] key_q [KeyDepth];
  logic [1:0]       key_idx_q = '0;
  logic [LenW-1:0]  offset_q = '0;

  wsdf_result_t frame_events_due [$];
  int fails = 0;
  int due_count = 0;
  int headers_seen = 0;
  int payload_seen = 0;

  assign fail_count_o    = fails;
  assign pending_o       = due_count;
  assign header_words_o  = headers_seen;
  assign payload_words_o = payload_seen;

  function automatic wsdf_result_t make_event(input logic kind, input logic [7:0] data,
                                              input logic [63:0] off, input logic last_word);
    wsdf_result_t ev;
    ev.event_kind     = kind;
    ev.fin_bit        = fin_q;
    ev.reserved_bits  = rsv_q;
    ev.frame_opcode   = opcode_q;
    ev.masked         = masked_q;
    ev.payload_length = len_q;
    ev.payload_byte   = data;
    ev.payload_offset = off;
    ev.frame_end      = last_word;
    return ev;
  endfunction

  function automatic wsdf_result_t header_done();
    key_idx_q = '0;
    offset_q  = '0;
    count_q   = '0;
    phase_q   = (len_q == '0) ? PhFirst : PhPayload;
    return make_event(EvHeader, 8'h00, '0, len_q == '0);
  endfunction

  // Returns 1 when the header ends here; otherwise the masking key follows.
  function automatic bit length_known(output wsdf_result_t ev);
    count_q = '0;
    ev = '0;
    if (masked_q) begin
      phase_q = PhKey;
      return 1'b0;
    end
    ev = header_done();
    return 1'b1;
  endfunction

  function automatic bit deframe_byte(input logic [7:0] b, output wsdf_result_t ev);
    logic [7:0] data;
    bit hit;
    hit = 1'b0;
    ev = '0;
    case (phase_q)
      PhSecond: begin
        masked_q = b[7];
        count_q  = '0;
        if (b[6:0] == Len7Ext16) begin
          len_q   = '0;
          phase_q = PhLen16;
        end else if (b[6:0] == Len7Ext64) begin
          len_q   = '0;
          phase_q = PhLen64;
        end else begin
          len_q = 64'(b[6:0]);
          hit   = length_known(ev);
        end
      end
      PhLen16: begin
        len_q = {48'd0, len_q[7:0], b};
        if (count_q >= 3'd1) hit = length_known(ev);
        else count_q = count_q + 3'd1;
      end
      PhLen64: begin
        len_q = {len_q[55:0], b};
        if (count_q >= 3'd7) hit = length_known(ev);
        else count_q = count_q + 3'd1;
      end
      PhKey: begin
        key_q[count_q[1:0]] = b;
        if (count_q >= 3'd3) begin
          ev  = header_done();
          hit = 1'b1;
        end else begin
          count_q = count_q + 3'd1;
        end
      end
      PhPayload: begin
        data = b;
        if (masked_q) begin
          data      = b ^ key_q[key_idx_q];
          key_idx_q = key_idx_q + 2'd1;
        end
        offset_q = offset_q + 64'd1;
        ev  = make_event(EvPayload, data, offset_q, offset_q == len_q);
        hit = 1'b1;
        if (offset_q == len_q) phase_q = PhFirst;
      end
      default: begin
        // Any phase code other than the ones above takes a first header byte.
        fin_q    = b[7];
        rsv_q    = b[6:4];
        opcode_q = b[3:0];
        count_q  = '0;
        phase_q  = PhSecond;
      end
    endcase
    return hit;
  endfunction

  function automatic int field_mismatch(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch_channels
    wsdf_result_t want;
    wsdf_result_t seen;
    int bad;
    if (!rst_ni) begin
      phase_q   = PhFirst;
      count_q   = '0;
      fin_q     = 1'b0;
      rsv_q     = '0;
      opcode_q  = '0;
      masked_q  = 1'b0;
      len_q     = '0;
      key_idx_q = '0;
      offset_q  = '0;
      foreach (key_q[i]) key_q[i] = '0;
      frame_events_due.delete();
    end else begin
      // Result side first, so a word cannot match an event decoded at the same edge.
      if (out_valid_i && out_ready_i) begin
        seen = {event_kind_i, fin_bit_i, reserved_bits_i, frame_opcode_i, masked_i,
                payload_length_i, payload_byte_i, payload_offset_i, frame_end_i};
        if (seen.event_kind == EvHeader) headers_seen++;
        else payload_seen++;
        if (frame_events_due.size() == 0) begin
          $error("result word arrived with no decoded event pending");
          fails++;
        end else begin
          want = frame_events_due.pop_front();
          bad = 0;
          bad += field_mismatch("event_kind", 64'(want.event_kind), 64'(seen.event_kind));
          bad += field_mismatch("fin_bit", 64'(want.fin_bit), 64'(seen.fin_bit));
          bad += field_mismatch("reserved_bits", 64'(want.reserved_bits),
                                64'(seen.reserved_bits));
          bad += field_mismatch("frame_opcode", 64'(want.frame_opcode),
                                64'(seen.frame_opcode));
          bad += field_mismatch("masked", 64'(want.masked), 64'(seen.masked));
          bad += field_mismatch("payload_length", want.payload_length, seen.payload_length);
          bad += field_mismatch("payload_byte", 64'(want.payload_byte),
                                64'(seen.payload_byte));
          bad += field_mismatch("payload_offset", want.payload_offset, seen.payload_offset);
          bad += field_mismatch("frame_end", 64'(want.frame_end), 64'(seen.frame_end));
          if (bad != 0) fails++;
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (deframe_byte(in_byte_i, want)) begin
          frame_events_due.insert(frame_events_due.size(), want);
        end
      end
    end
    due_count = frame_events_due.size();
  end

endmodule

// ----- dv/testbench.sv -----
// Top of the deframer testbench: clock, reset, byte stream and result-side stalls.
// Needs websocket_frame_deframer_top, wsdf_pkg and the wsdf_stream_checker module.
`timescale 1ns / 100ps

module testbench import wsdf_pkg::*; ();

  typedef enum int {LenShort, LenExt16, LenExt64} len_form_e;

  localparam int unsigned StreamBytes = 1850;
  localparam int unsigned QuietFrom   = 1600;
  localparam int unsigned LongHold    = 64;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  logic [ByteW-1:0] in_byte_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic             event_kind_o;
  logic             fin_bit_o;
  logic [2:0]       reserved_bits_o;
  logic [3:0]       frame_opcode_o;
  logic             masked_o;
  logic [LenW-1:0]  payload_length_o;
  logic [ByteW-1:0] payload_byte_o;
  logic [LenW-1:0]  payload_offset_o;
  logic             frame_end_o;

  int fail_count;
  int pending;
  int header_words;
  int payload_words;

  int unsigned bytes_sent = 0;
  bit gaps_on = 1'b0;
  bit hold_request = 1'b0;

  websocket_frame_deframer_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .in_byte_i       (in_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .event_kind_o    (event_kind_o),
    .fin_bit_o       (fin_bit_o),
    .reserved_bits_o (reserved_bits_o),
    .frame_opcode_o  (frame_opcode_o),
    .masked_o        (masked_o),
    .payload_length_o(payload_length_o),
    .payload_byte_o  (payload_byte_o),
    .payload_offset_o(payload_offset_o),
    .frame_end_o     (frame_end_o)
  );

  wsdf_stream_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .in_byte_i       (in_byte_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .event_kind_i    (event_kind_o),
    .fin_bit_i       (fin_bit_o),
    .reserved_bits_i (reserved_bits_o),
    .frame_opcode_i  (frame_opcode_o),
    .masked_i        (masked_o),
    .payload_length_i(payload_length_o),
    .payload_byte_i  (payload_byte_o),
    .payload_offset_i(payload_offset_o),
    .frame_end_i     (frame_end_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .header_words_o  (header_words),
    .payload_words_o (payload_words)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Result side: short random stalls, plus one long hold-off on request.
  initial begin
    out_ready_i = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready_i <= 1'b0;
        repeat (LongHold) @(negedge clk_i);
      end else if (gaps_on && $urandom_range(0, 6) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(0, 4)) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Called at a falling edge; returns at a falling edge after the word is taken.
  task automatic send_word(input logic [7:0] b);
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
    @(negedge clk_i);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
  endtask

  task automatic send_frame(input logic [7:0] first, input bit mask, input len_form_e form,
                            input logic [63:0] len, input int unsigned body);
    logic [6:0] len7;
    case (form)
      LenShort: len7 = len[6:0];
      LenExt16: len7 = Len7Ext16;
      default:  len7 = Len7Ext64;
    endcase
    send_word(first);
    send_word({mask, len7});
    if (form == LenExt16) begin
      for (int i = 1; i >= 0; i--) send_word(len[8*i +: 8]);
    end else if (form == LenExt64) begin
      for (int i = 7; i >= 0; i--) send_word(len[8*i +: 8]);
    end
    if (mask) repeat (4) send_word(8'($urandom_range(0, 255)));
    repeat (body) send_word(8'($urandom_range(0, 255)));
  endtask

  // Zero length, masked single byte with extreme key bytes, 16-bit length of zero,
  // and a non-minimal 64-bit length of two.
  logic [7:0] directed_bytes [25] = '{
    8'h80, 8'h00,
    8'h7F, 8'h81, 8'hFF, 8'h00, 8'hA5, 8'h5A, 8'hFF,
    8'h01, 8'h7E, 8'h00, 8'h00,
    8'h8A, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02, 8'h00, 8'hFF
  };

  initial begin
    int unsigned pick;
    bit mask;
    len_form_e form;
    logic [63:0] len;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_byte_i  = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_bytes[i]) send_word(directed_bytes[i]);

    // The long hold-off lands early in the random stream, with the sender busy.
    gaps_on = 1'b1;
    hold_request = 1'b1;
    while (bytes_sent < StreamBytes) begin
      if (bytes_sent >= QuietFrom) gaps_on = 1'b0;
      pick = $urandom_range(0, 99);
      mask = 1'($urandom_range(0, 1));
      if (pick < 70) begin
        form = LenShort;
        len  = 64'((pick < 60) ? $urandom_range(0, 24) : $urandom_range(0, 125));
      end else if (pick < 85) begin
        form = LenExt16;
        len  = 64'(($urandom_range(0, 3) == 0) ? $urandom_range(126, 300)
                                               : $urandom_range(0, 40));
      end else begin
        form = LenExt64;
        len  = 64'($urandom_range(0, 40));
      end
      send_frame(8'($urandom_range(0, 255)), mask, form, len, 32'(len));
    end
    gaps_on = 1'b0;

    // A frame whose payload never completes: exercises the upper length bits.
    len = {1'b1, 31'($urandom), 32'($urandom)};
    send_frame(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), LenExt64, len, 12);
    in_valid_i <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);

    $display("Sent %0d stream bytes; checked %0d header words and %0d payload words.",
             bytes_sent, header_words, payload_words);
    $display("Lengths covered 7-bit, 16-bit and 64-bit forms, masked and unmasked.");
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
